// ===== rtl/percent_escape_codec_macros.svh =====
// ----------------------------------------------------------------------------
// percent_escape_codec_macros
// assertion macros used by the codec back end (pec_back)
// ----------------------------------------------------------------------------
`ifndef PERCENT_ESCAPE_CODEC_MACROS_SVH
`define PERCENT_ESCAPE_CODEC_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PEC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define PEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pec_pkg.sv =====
// ----------------------------------------------------------------------------
// pec_pkg
// types, character constants and helpers for the percent-escape codec
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pec_pkg;

  localparam int PEC_QDEPTH = 4;

  localparam logic [7:0] CH_PCT     = 8'h25;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } pec_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       truncated;
  } pec_out_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_HI   = 2'd2
  } phase_t;

  typedef enum logic {
    CMD_EMIT = 1'b0,
    CMD_ESC  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       last;
    logic       trunc;
  } pec_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } pec_qstat_t;

  function automatic logic [7:0] nibble_to_hex(input logic [3:0] n);
    logic [7:0] w;
    w = {4'd0, n};
    return (n <= 4'd9) ? (w + CH_ZERO) : (w + (CH_UPPER_A - 8'd10));
  endfunction

endpackage

// ===== rtl/pec_front.sv =====
// ----------------------------------------------------------------------------
// pec_front
// accepts input words, tracks escape state and queues output commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pec_front
  import pec_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  pec_in_t  in_data,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  logic     q_full,
  output logic     push,
  output pec_cmd_t cmd
);

  logic       mode_r;
  phase_t     phase_r, phase_nxt;
  logic [3:0] hi_r, hi_nxt;
  logic       accept;
  logic [7:0] b;
  logic       last;
  logic [7:0] hv;
  logic [7:0] sum;
  logic       is_digit;
  logic       is_plain;
  logic       is_pct;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign b        = in_data.in_byte;
  assign last     = in_data.in_last;

  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_pct   = (b == CH_PCT);
  assign is_plain = is_digit
                 || ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z))
                 || ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z))
                 || (b == CH_DOT) || (b == CH_COMMA)
                 || (b == CH_DASH) || (b == CH_UNDER);

  assign hv  = is_digit ? (b - CH_ZERO) : (b + 8'd10 - CH_UPPER_A);
  assign sum = {hi_r, 4'd0} + hv;

  // next escape state
  always_comb begin
    phase_nxt = phase_r;
    hi_nxt    = hi_r;
    if (accept && mode_r) begin
      unique case (phase_r)
        PH_PCT: begin
          if (last) begin
            phase_nxt = PH_IDLE;
            hi_nxt    = 4'd0;
          end else begin
            phase_nxt = PH_HI;
            hi_nxt    = hv[3:0];
          end
        end
        PH_HI: begin
          phase_nxt = PH_IDLE;
          hi_nxt    = 4'd0;
        end
        default: begin
          phase_nxt = (is_pct && !last) ? PH_PCT : PH_IDLE;
        end
      endcase
    end
  end

  // command toward the back end
  always_comb begin
    push       = 1'b0;
    cmd.kind   = CMD_EMIT;
    cmd.data   = b;
    cmd.last   = last;
    cmd.trunc  = 1'b0;
    if (!mode_r) begin
      push = accept;
      if (!is_plain) begin
        cmd.kind = CMD_ESC;
      end
    end else begin
      unique case (phase_r)
        PH_PCT: begin
          push      = accept && last;
          cmd.data  = 8'd0;
          cmd.last  = 1'b1;
          cmd.trunc = 1'b1;
        end
        PH_HI: begin
          push     = accept;
          cmd.data = sum;
        end
        default: begin
          if (is_pct) begin
            push      = accept && last;
            cmd.data  = 8'd0;
            cmd.last  = 1'b1;
            cmd.trunc = 1'b1;
          end else begin
            push = accept;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      phase_r <= PH_IDLE;
      hi_r    <= 4'd0;
    end else if (cfg_we) begin
      mode_r  <= cfg_wdata;
      phase_r <= PH_IDLE;
      hi_r    <= 4'd0;
    end else begin
      phase_r <= phase_nxt;
      hi_r    <= hi_nxt;
    end
  end

endmodule

// ===== rtl/pec_fifo.sv =====
// ----------------------------------------------------------------------------
// pec_fifo
// small command queue between front and back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pec_fifo
  import pec_pkg::*;
#(
  parameter int DEPTH = PEC_QDEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  pec_cmd_t   push_data,
  input  logic       pop,
  output pec_cmd_t   head,
  output pec_qstat_t qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pec_cmd_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign head        = mem_r[rd_ptr_r];
  assign qstat.empty = (cnt_r == '0);
  assign qstat.full  = (cnt_r == CNT_W'(DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/pec_back.sv =====
// ----------------------------------------------------------------------------
// pec_back
// expands queued commands into output words through an output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "percent_escape_codec_macros.svh"

module pec_back
  import pec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  pec_cmd_t   q_head,
  input  pec_qstat_t qstat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output pec_out_t   out_data
);

  logic       out_valid_r, out_valid_nxt;
  pec_out_t   out_r, out_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  pec_cmd_t   cmd_r, cmd_nxt;
  logic       advance;

  assign advance   = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    cmd_nxt       = cmd_r;
    pop           = 1'b0;
    if (advance) begin
      if (busy_r) begin
        out_valid_nxt = 1'b1;
        case (idx_r)
          2'd1: begin
            out_nxt = '{out_byte: nibble_to_hex(cmd_r.data[7:4]),
                        out_last: 1'b0, truncated: 1'b0};
            idx_nxt = 2'd2;
          end
          default: begin
            out_nxt  = '{out_byte: nibble_to_hex(cmd_r.data[3:0]),
                         out_last: cmd_r.last, truncated: 1'b0};
            idx_nxt  = 2'd0;
            busy_nxt = 1'b0;
          end
        endcase
      end else if (!qstat.empty) begin
        pop           = 1'b1;
        out_valid_nxt = 1'b1;
        if (q_head.kind == CMD_ESC) begin
          out_nxt  = '{out_byte: CH_PCT, out_last: 1'b0, truncated: 1'b0};
          cmd_nxt  = q_head;
          busy_nxt = 1'b1;
          idx_nxt  = 2'd1;
        end else begin
          out_nxt = '{out_byte: q_head.data, out_last: q_head.last,
                      truncated: q_head.trunc};
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    cmd_r <= cmd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
    end
  end

  `PEC_ASSERT_IMPL(a_pop_nonempty, pop, !qstat.empty, "pop from empty queue")
  `PEC_ASSERT_IMPL(a_busy_idx, busy_r, idx_r != 2'd0, "escape sequencer index lost")
  `PEC_ASSERT_IMPL(a_pct_first, out_valid_r && busy_r && (idx_r == 2'd1), out_r.out_byte == CH_PCT, "escape not led by percent")
  `PEC_ASSERT_IMPL(a_trunc_last, out_valid_r && out_r.truncated, out_r.out_last, "truncated word not last")

endmodule

// ===== rtl/percent_escape_codec.sv =====
// ----------------------------------------------------------------------------
// percent_escape_codec
// streaming percent-escape encoder and decoder
// ----------------------------------------------------------------------------
// cfg_we/cfg_wdata select encode (0) or decode (1) and reset the escape
// state; write only while idle. in decode mode every input word is taken
// while the queue is not full. in encode mode a plain word produces one
// output word per cycle while out_stall is low, and an escaped word
// produces three output words, a percent sign and two hex digits; a queue
// of QDEPTH commands lets the input side keep accepting while the output
// side works through an escape or is stalled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module percent_escape_codec
  import pec_pkg::*;
#(
  parameter int QDEPTH = PEC_QDEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  pec_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output pec_out_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);

  logic       push;
  logic       pop;
  pec_cmd_t   cmd;
  pec_cmd_t   q_head;
  pec_qstat_t qstat;

  pec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (qstat.full),
    .push      (push),
    .cmd       (cmd)
  );

  pec_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cmd),
    .pop       (pop),
    .head      (q_head),
    .qstat     (qstat)
  );

  pec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
